// File: design/powerpc_fixed_point_alu_carry_overflow_core_assert.svh
// Assertion macros shared by the fixed-point ALU core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POWERPC_FIXED_POINT_ALU_CARRY_OVERFLOW_CORE_ASSERT_SVH
`define POWERPC_FIXED_POINT_ALU_CARRY_OVERFLOW_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pfa_pkg.sv
// Shared types, opcodes and helpers for the fixed-point ALU core.
// No dependencies; used by pfa_alu, pfa_div and the top level.
package pfa_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [3:0]        opcode_t;

    // Opcodes
    localparam opcode_t OP_ADD    = 4'd0;
    localparam opcode_t OP_ADDC   = 4'd1;
    localparam opcode_t OP_ADDE   = 4'd2;
    localparam opcode_t OP_ADDME  = 4'd3;
    localparam opcode_t OP_ADDZE  = 4'd4;
    localparam opcode_t OP_SUBF   = 4'd5;
    localparam opcode_t OP_SUBFC  = 4'd6;
    localparam opcode_t OP_SUBFE  = 4'd7;
    localparam opcode_t OP_SUBFME = 4'd8;
    localparam opcode_t OP_SUBFZE = 4'd9;
    localparam opcode_t OP_NEG    = 4'd10;
    localparam opcode_t OP_MULLW  = 4'd11;
    localparam opcode_t OP_DIVW   = 4'd12;
    localparam opcode_t OP_DIVWU  = 4'd13;
    localparam opcode_t OP_SRAW   = 4'd14;

    localparam word_t ALL_ONES = 32'hffff_ffff;
    localparam word_t SIGN_BIT = 32'h8000_0000;

    // XER-style flag pair
    typedef struct packed {
        logic carry;
        logic overflow;
    } pfa_flags_t;

    // Divides that take the architected answer instead of the divider
    function automatic logic div_special(opcode_t op, word_t a, word_t b);
        logic zero_div;
        logic ovf_div;
        begin
            zero_div = (b == '0);
            ovf_div  = (a == SIGN_BIT) && (b == ALL_ONES);
            return ((op == OP_DIVW) && (zero_div || ovf_div)) ||
                   ((op == OP_DIVWU) && zero_div);
        end
    endfunction

endpackage

// File: design/pfa_div.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// Depends on pfa_pkg.
module pfa_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pfa_pkg::word_t dividend,
    input  pfa_pkg::word_t divisor,
    output logic          done,
    output pfa_pkg::word_t quotient
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    word_t             rem_reg;
    word_t             quo_reg;
    word_t             dvs_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              take;

    // One trial subtract per cycle
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = !diff[DATA_W];

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last step
            done_reg <= busy_reg && !start && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/pfa_alu.sv
// Result and flag formation: 33-bit adder, shifter, neg, and final
// shaping of multiply and divide results. Depends on pfa_pkg.
module pfa_alu (
    input  pfa_pkg::opcode_t   op,
    input  logic               oe,
    input  pfa_pkg::word_t     a,
    input  pfa_pkg::word_t     b,
    input  logic [63:0]        product,
    input  pfa_pkg::word_t     quotient,
    input  pfa_pkg::pfa_flags_t flags_in,
    output pfa_pkg::word_t     result,
    output pfa_pkg::pfa_flags_t flags_out
);
    import pfa_pkg::*;

    word_t           add_x;
    word_t           add_y;
    logic            add_cin;
    logic [DATA_W:0] add_sum;
    word_t           add_ovf_word;
    logic            add_ovf;
    logic [4:0]      sh_amt;
    word_t           sra_val;
    word_t           sra_mask;
    logic            sra_lost;
    logic            special;

    // Adder operand and carry-in selection
    always_comb
    begin
        case (op) inside
            OP_SUBF, OP_SUBFC, OP_SUBFE, OP_SUBFME, OP_SUBFZE: add_x = ~a;
            default: add_x = a;
        endcase
        case (op) inside
            OP_ADDME, OP_SUBFME: add_y = ALL_ONES;
            OP_ADDZE, OP_SUBFZE: add_y = '0;
            default: add_y = b;
        endcase
        case (op) inside
            OP_ADD, OP_ADDC:   add_cin = 1'b0;
            OP_SUBF, OP_SUBFC: add_cin = 1'b1;
            default:           add_cin = flags_in.carry;
        endcase
    end

    assign add_sum      = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign add_ovf_word = (add_x ^ add_sum[DATA_W-1:0]) & (add_y ^ add_sum[DATA_W-1:0]);
    assign add_ovf      = add_ovf_word[DATA_W-1];

    // Arithmetic shift right and shifted-out bits
    assign sh_amt   = b[4:0];
    assign sra_val  = word_t'($signed(a) >>> sh_amt);
    assign sra_mask = ~(ALL_ONES << sh_amt);
    assign sra_lost = |(a & sra_mask);

    assign special  = div_special(op, a, b);

    // Result mux and flag update
    always_comb
    begin
        result    = '0;
        flags_out = flags_in;
        case (op) inside
            OP_ADD, OP_SUBF:
            begin
                result = add_sum[DATA_W-1:0];
                if (oe)
                    flags_out.overflow = add_ovf;
            end
            OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE,
            OP_SUBFC, OP_SUBFE, OP_SUBFME, OP_SUBFZE:
            begin
                result          = add_sum[DATA_W-1:0];
                flags_out.carry = add_sum[DATA_W];
                if (oe)
                    flags_out.overflow = add_ovf;
            end
            OP_NEG:
            begin
                result = ~a + 1'b1;
                if (oe)
                    flags_out.overflow = (a == SIGN_BIT);
            end
            OP_MULLW:
            begin
                result = product[DATA_W-1:0];
                if (oe)
                    flags_out.overflow = (product[63:32] != {DATA_W{product[DATA_W-1]}});
            end
            OP_DIVW:
            begin
                if (special)
                    result = {DATA_W{a[DATA_W-1]}};
                else if (a[DATA_W-1] ^ b[DATA_W-1])
                    result = ~quotient + 1'b1;
                else
                    result = quotient;
                if (oe)
                    flags_out.overflow = special;
            end
            OP_DIVWU:
            begin
                result = special ? '0 : quotient;
                if (oe)
                    flags_out.overflow = special;
            end
            OP_SRAW:
            begin
                if (b[5])
                begin
                    result          = {DATA_W{a[DATA_W-1]}};
                    flags_out.carry = a[DATA_W-1];
                end
                else
                begin
                    result          = sra_val;
                    flags_out.carry = a[DATA_W-1] && sra_lost;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// File: design/powerpc_fixed_point_alu_carry_overflow_core.sv
// Fixed-point ALU with carry and overflow flags. One beat in, one beat out:
// add, add-carrying/extended, subtract-from variants, neg, mullw and sraw
// go from accept through the execute and finish states (the mullw product is
// registered in the execute cycle), and divw/divwu also pass a divide state
// for the 32 steps of the shared restoring divider. Divides by zero and the
// signed overflow case skip the divider and its state. A result beat still held in
// the output register stretches the finish cycle until it drains. The input
// is not ready while an item is in work; a finished result waits in the
// output register while the next item is accepted. Flags reset to zero.
`include "powerpc_fixed_point_alu_carry_overflow_core_assert.svh"

module powerpc_fixed_point_alu_carry_overflow_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [4:0]  s_tuser,   // op[3:0], oe[4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result[31:0], carry[32], overflow[33], zero[39:34]
);
    import pfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    opcode_t      op_reg;
    logic         oe_reg;
    word_t        a_reg;
    word_t        b_reg;
    logic [63:0]  product_reg;
    pfa_flags_t   flags_reg;
    pfa_flags_t   flags_next;
    logic         out_valid_reg;
    logic [39:0]  out_data_reg;

    logic         in_beat;
    logic         fin_load;
    logic         is_div;
    logic         div_start;
    logic         div_done;
    word_t        div_dvd;
    word_t        div_dvs;
    word_t        quotient;
    word_t        alu_result;
    logic signed [63:0] prod_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    assign is_div   = (op_reg == OP_DIVW) || (op_reg == OP_DIVWU);
    assign div_start = (state_reg == ST_EXEC) && is_div && !div_special(op_reg, a_reg, b_reg);

    // Magnitudes for the unsigned divider
    assign div_dvd = ((op_reg == OP_DIVW) && a_reg[DATA_W-1]) ? ~a_reg + 1'b1 : a_reg;
    assign div_dvs = ((op_reg == OP_DIVW) && b_reg[DATA_W-1]) ? ~b_reg + 1'b1 : b_reg;

    assign prod_full = $signed(a_reg) * $signed(b_reg);

    pfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quotient)
    );

    pfa_alu u_alu (
        .op        (op_reg),
        .oe        (oe_reg),
        .a         (a_reg),
        .b         (b_reg),
        .product   (product_reg),
        .quotient  (quotient),
        .flags_in  (flags_reg),
        .result    (alu_result),
        .flags_out (flags_next)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_beat)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = div_start ? ST_DIV : ST_FIN;
            ST_DIV:
                if (div_done)
                    state_next = ST_FIN;
            ST_FIN:
                if (fin_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state, flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_load)
            begin
                flags_reg     <= flags_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operand, product and output payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg <= s_tuser[3:0];
            oe_reg <= s_tuser[4];
            a_reg  <= s_tdata[31:0];
            b_reg  <= s_tdata[63:32];
        end
        if (state_reg == ST_EXEC)
            product_reg <= prod_full;
        if (fin_load)
            out_data_reg <= {6'd0, flags_next.overflow, flags_next.carry, alu_result};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PFA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input accepted while busy")
    `PFA_ASSERT_NEXT(a_div_to_fin, (state_reg == ST_DIV) && div_done, state_reg == ST_FIN, "divide done lost")
    `PFA_ASSERT_SAME(a_out_slot_free, fin_load, !m_tvalid || m_tready, "result overwrote pending beat")
    `PFA_ASSERT_NEXT(a_flags_hold, !fin_load, $stable(flags_reg), "flags changed outside result load")

endmodule

// File: bench/tb_powerpc_fixed_point_alu_carry_overflow_core.sv
// Self-checking bench for the fixed-point ALU core with carry and overflow flags.
// Needs pfa_pkg and powerpc_fixed_point_alu_carry_overflow_core; stimulus is
// directed corner cases followed by weighted random beats.
module tb_powerpc_fixed_point_alu_carry_overflow_core;
    import pfa_pkg::*;

    typedef struct packed {
        opcode_t op;
        logic    oe;
        word_t   a;
        word_t   b;
    } alu_req_t;

    typedef struct packed {
        word_t value;
        logic  ca;
        logic  ov;
    } alu_res_t;

    localparam int NUM_RANDOM = 1250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // operand_a[31:0], operand_b[63:32]
    logic [4:0]  s_tuser = '0;   // op[3:0], oe[4]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // result[31:0], carry[32], overflow[33], zero[39:34]

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    alu_req_t next_req;
    alu_res_t got, want;
    logic     xer_ca = 1'b0;
    logic     xer_ov = 1'b0;
    int       n_accepted = 0;
    int       mismatches = 0;

    // no idling on either side while this window of beats goes through
    wire calm = (n_accepted >= 500) && (n_accepted < 700);

    powerpc_fixed_point_alu_carry_overflow_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Expected result of one op; updates the bench copy of CA and OV
    function automatic alu_res_t alu_predict(opcode_t op, logic oe, word_t a, word_t b);
        alu_res_t        r;
        logic            use_adder;
        logic            set_ca;
        logic            set_ov;
        logic            cin;
        logic            co;
        logic            ov;
        word_t           x;
        word_t           y;
        word_t           res;
        word_t           ma;
        word_t           mb;
        word_t           q;
        logic [32:0]     sum;
        logic signed [63:0] prod;
        logic [5:0]      n;
        begin
            use_adder = 1'b0;
            set_ca = 1'b0;
            set_ov = 1'b0;
            cin = 1'b0;
            co = 1'b0;
            ov = 1'b0;
            x = '0;
            y = '0;
            res = '0;
            case (op)
                OP_ADD, OP_ADDC:
                begin
                    x = a; y = b; cin = 1'b0; use_adder = 1'b1;
                end
                OP_ADDE:
                begin
                    x = a; y = b; cin = xer_ca; use_adder = 1'b1;
                end
                OP_ADDME:
                begin
                    x = a; y = ALL_ONES; cin = xer_ca; use_adder = 1'b1;
                end
                OP_ADDZE:
                begin
                    x = a; y = '0; cin = xer_ca; use_adder = 1'b1;
                end
                OP_SUBF, OP_SUBFC:
                begin
                    x = ~a; y = b; cin = 1'b1; use_adder = 1'b1;
                end
                OP_SUBFE:
                begin
                    x = ~a; y = b; cin = xer_ca; use_adder = 1'b1;
                end
                OP_SUBFME:
                begin
                    x = ~a; y = ALL_ONES; cin = xer_ca; use_adder = 1'b1;
                end
                OP_SUBFZE:
                begin
                    x = ~a; y = '0; cin = xer_ca; use_adder = 1'b1;
                end
                OP_NEG:
                begin
                    res = '0 - a;
                    ov = (a == SIGN_BIT);
                    set_ov = oe;
                end
                OP_MULLW:
                begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    res = prod[31:0];
                    ov = (prod[63:32] != {32{prod[31]}});
                    set_ov = oe;
                end
                OP_DIVW:
                begin
                    if ((b == '0) || ((a == SIGN_BIT) && (b == ALL_ONES)))
                    begin
                        res = a[31] ? ALL_ONES : '0;
                        ov = 1'b1;
                    end
                    else
                    begin
                        ma = a[31] ? ('0 - a) : a;
                        mb = b[31] ? ('0 - b) : b;
                        q = ma / mb;
                        res = (a[31] ^ b[31]) ? ('0 - q) : q;
                        ov = 1'b0;
                    end
                    set_ov = oe;
                end
                OP_DIVWU:
                begin
                    if (b == '0)
                    begin
                        res = '0;
                        ov = 1'b1;
                    end
                    else
                    begin
                        res = a / b;
                        ov = 1'b0;
                    end
                    set_ov = oe;
                end
                OP_SRAW:
                begin
                    n = b[5:0];
                    if (n[5])
                    begin
                        res = {32{a[31]}};
                        co = a[31];
                    end
                    else
                    begin
                        res = a[31] ? ~((~a) >> n[4:0]) : (a >> n[4:0]);
                        co = a[31] && ((a & ~(ALL_ONES << n[4:0])) != '0);
                    end
                    set_ca = 1'b1;
                end
                default:
                begin
                    res = '0;
                end
            endcase

            // shared 33-bit adder for the add and subtract-from families
            if (use_adder)
            begin
                sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
                res = sum[31:0];
                co = sum[32];
                ov = (x[31] ^ res[31]) & (y[31] ^ res[31]);
                set_ca = (op != OP_ADD) && (op != OP_SUBF);
                set_ov = oe;
            end

            if (set_ca)
                xer_ca = co;
            if (set_ov)
                xer_ov = ov;
            r.value = res;
            r.ca = xer_ca;
            r.ov = xer_ov;
            return r;
        end
    endfunction

    task automatic queue_req(opcode_t op, logic oe, word_t a, word_t b);
        alu_req_t r;
        begin
            r.op = op;
            r.oe = oe;
            r.a = a;
            r.b = b;
            pending_reqs.push_back(r);
        end
    endtask

    // Operand with a bias toward the boundary values
    function automatic word_t pick_word();
        word_t v;
        begin
            case ($urandom_range(0, 11))
                0: v = '0;
                1: v = 32'd1;
                2: v = ALL_ONES;
                3: v = SIGN_BIT;
                4: v = 32'h7fff_ffff;
                5: v = $urandom_range(0, 255);
                6: v = '0 - $urandom_range(1, 255);
                default: v = $urandom;
            endcase
            return v;
        end
    endfunction

    // Input driver: holds a beat until taken, idles at random between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(alu_predict(s_tuser[3:0], s_tuser[4],
                                                       s_tdata[31:0], s_tdata[63:32]));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if ((pending_reqs.size() != 0) && (calm || ($urandom_range(0, 99) >= 36)))
                begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {next_req.b, next_req.a};
                    s_tuser <= {next_req.oe, next_req.op};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random back-pressure, checks each result beat in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[31:0];
                got.ca = m_tdata[32];
                got.ov = m_tdata[33];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, actual %h ca %b ov %b",
                             $time, got.value, got.ca, got.ov);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: result mismatch, expected %h actual %h",
                                 $time, want.value, got.value);
                    end
                    if (got.ca !== want.ca)
                    begin
                        mismatches++;
                        $display("%0t: carry mismatch, expected %b actual %b",
                                 $time, want.ca, got.ca);
                    end
                    if (got.ov !== want.ov)
                    begin
                        mismatches++;
                        $display("%0t: overflow mismatch, expected %b actual %b",
                                 $time, want.ov, got.ov);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    // Stimulus and end of run
    initial begin
        opcode_t op;
        word_t   a;
        word_t   b;

        // carry and overflow corners of the add family
        queue_req(OP_ADDC, 1'b1, ALL_ONES, 32'd1);
        queue_req(OP_ADDE, 1'b1, 32'h7fff_ffff, 32'd0);
        queue_req(OP_ADD, 1'b0, 32'h7fff_ffff, 32'd1);
        queue_req(OP_ADD, 1'b1, SIGN_BIT, SIGN_BIT);
        queue_req(OP_ADDME, 1'b1, 32'd0, ALL_ONES);
        queue_req(OP_ADDZE, 1'b1, ALL_ONES, 32'h1234_5678);
        // subtract-from family, borrow and overflow
        queue_req(OP_SUBF, 1'b1, 32'd1, SIGN_BIT);
        queue_req(OP_SUBFC, 1'b1, 32'd0, 32'd0);
        queue_req(OP_SUBFE, 1'b0, ALL_ONES, 32'h7fff_ffff);
        queue_req(OP_SUBFME, 1'b1, SIGN_BIT, 32'd0);
        queue_req(OP_SUBFZE, 1'b1, ALL_ONES, ALL_ONES);
        // negate of the most negative value, and of zero
        queue_req(OP_NEG, 1'b1, SIGN_BIT, ALL_ONES);
        queue_req(OP_NEG, 1'b0, 32'd0, 32'd0);
        // multiply overflow and sign handling
        queue_req(OP_MULLW, 1'b1, 32'h7fff_ffff, 32'd2);
        queue_req(OP_MULLW, 1'b1, ALL_ONES, ALL_ONES);
        queue_req(OP_MULLW, 1'b1, SIGN_BIT, ALL_ONES);
        // architected divide answers and ordinary quotients
        queue_req(OP_DIVW, 1'b1, SIGN_BIT, ALL_ONES);
        queue_req(OP_DIVW, 1'b1, 32'h8000_0005, 32'd0);
        queue_req(OP_DIVW, 1'b1, 32'd7, 32'd0);
        queue_req(OP_DIVW, 1'b1, 32'hffff_fff9, 32'd2);
        queue_req(OP_DIVWU, 1'b1, 32'd5, 32'd0);
        queue_req(OP_DIVWU, 1'b1, ALL_ONES, 32'd1);
        // shifts: carry out of a negative value, amounts of 32 and up
        queue_req(OP_SRAW, 1'b1, 32'h8000_0001, 32'd1);
        queue_req(OP_SRAW, 1'b0, SIGN_BIT, 32'h0000_0020);
        queue_req(OP_SRAW, 1'b1, 32'h7fff_ffff, ALL_ONES);
        queue_req(OP_SRAW, 1'b0, SIGN_BIT, 32'd31);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            op = opcode_t'($urandom_range(0, 14));
            a = pick_word();
            b = pick_word();
            if ((op == OP_DIVW) || (op == OP_DIVWU))
            begin
                case ($urandom_range(0, 7))
                    0: b = '0;
                    1: begin a = SIGN_BIT; b = ALL_ONES; end
                    2: b = $urandom_range(1, 15);
                    default: ;
                endcase
            end
            queue_req(op, 1'($urandom_range(0, 1)), a, b);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_reqs.size() != 0) || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pfa_pkg.sv
design/pfa_div.sv
design/pfa_alu.sv
design/powerpc_fixed_point_alu_carry_overflow_core.sv
bench/tb_powerpc_fixed_point_alu_carry_overflow_core.sv
